>>> design/q6k_q8k_integer_dot_product_top_assert.svh
// Assertion helpers shared by the dot-product block.
`ifndef Q6K_Q8K_INTEGER_DOT_PRODUCT_TOP_ASSERT_SVH
`define Q6K_Q8K_INTEGER_DOT_PRODUCT_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define Q6K_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define Q6K_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/q6kq8k_pkg.sv
`timescale 1ns / 1ps

package q6kq8k_pkg;

    localparam int LANES      = 16;
    localparam int LANE_BYTES = 8;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 6;
    localparam int PROD_W     = 14;
    localparam int TREE_W     = PROD_W + $clog2(LANES);
    localparam int GSUM_W     = 12;
    localparam int GSUM_SHIFT = 5;
    localparam int DIFF_W     = 19;
    localparam int SCALE_W    = 8;
    localparam int CONTRIB_W  = DIFF_W + SCALE_W;
    localparam int BLOCK_W    = 32;
    localparam int ACC_W      = 64;
    localparam int HALF_W     = 16;
    localparam int MANT_W     = 11;
    localparam int SM_W       = BLOCK_W + MANT_W;
    localparam int SPLIT_W    = 22;
    localparam int PLO_W      = SPLIT_W + BLOCK_W;
    localparam int PHI_W      = SM_W - SPLIT_W + BLOCK_W;
    localparam int PROD_FULL_W = 76;
    localparam int LSHIFT_MAX = 5;
    localparam int SHIFTED_W  = PROD_FULL_W + LSHIFT_MAX;
    localparam int RSHIFT_W   = 5;
    localparam int LSHIFT_W   = 3;

    localparam logic [4:0]        FP16_EXP_MAX   = 5'h1F;
    localparam logic [4:0]        FP16_UNBIAS    = 5'd25;
    localparam logic [4:0]        SUBNORM_SHIFT  = 5'd24;
    localparam logic [MANT_W-1:0] FP16_INF_MANT  = 11'h7FF;

    localparam logic [1:0] END_NONE    = 2'd0;
    localparam int         END_ROW_BIT = 1;

    typedef struct packed {
        logic [63:0]        low_bits_first;
        logic [63:0]        low_bits_second;
        logic [63:0]        high_bits_first;
        logic [63:0]        high_bits_second;
        logic [1:0]         group_position;
        logic [63:0]        act_first;
        logic [63:0]        act_second;
        logic signed [7:0]  sub_scale;
        logic signed [11:0] group_act_sum;
        logic [15:0]        weight_block_scale;
        logic signed [31:0] act_block_scale;
        logic [1:0]         end_mark;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] row_sum;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [BLOCK_W-1:0]        sum;
        logic [HALF_W-1:0]         half;
        logic signed [BLOCK_W-1:0] act_scale;
        logic                      row_end;
    } t_blk_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL_A,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_ROUND,
        S_SHIFT,
        S_SAT,
        S_ACC,
        S_EMIT
    } t_scale_state;

endpackage

>>> design/q6k_q8k_integer_dot_product_top.sv
// Q6_K weight group times Q8_K activations, accumulated into one row sum.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer per 16-element
// group. Sixteen lanes decode the 6-bit codes and multiply them by the activations;
// a registered adder tree merges the lanes, and the scaled group term is registered
// and then added to the super-block sum.
// Groups without an end mark are taken one per cycle while the scaling unit is idle.
// A group that closes a super-block starts the scaling unit (fp16 decode, split 43x32
// multiply, rounding, shift, saturation, row add), which holds o_in_ready low while it
// works; a row end adds an emit state that loads the output register once it is free.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transfer per row,
// loaded once the scaling unit has added the row's last super-block.
// The output register holds the result while the receiver stalls; further groups
// are still taken, and only the next row end waits for the register to empty.
// Reset (synchronous, active low) clears the super-block sum, the row sum, the
// saturation flag and all valid bits.
`timescale 1ns / 1ps
`include "q6k_q8k_integer_dot_product_top_assert.svh"

module q6k_q8k_integer_dot_product_top
    import q6kq8k_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic signed [PROD_W-1:0]    w_prod [LANES];
    logic signed [PROD_W-1:0]    r_s1_prod [LANES];
    logic                        r_s1_valid, r_s2_valid, r_s3_valid;
    logic signed [SCALE_W-1:0]   r_s1_sc, r_s2_sc;
    logic signed [GSUM_W-1:0]    r_s1_gs;
    logic [HALF_W-1:0]           r_s1_half, r_s2_half, r_s3_half;
    logic signed [BLOCK_W-1:0]   r_s1_xd, r_s2_xd, r_s3_xd;
    logic [1:0]                  r_s1_end, r_s2_end, r_s3_end;
    logic signed [DIFF_W-1:0]    w_diff;
    logic signed [CONTRIB_W-1:0] w_contrib;
    logic signed [CONTRIB_W-1:0] r_s3_contrib;
    logic [BLOCK_W-1:0]          r_block_sum, n_block_sum;
    logic                        w_busy, w_adv, w_start;
    t_blk_req                    w_req;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam int OFS = (l % LANE_BYTES) * BYTE_W;
        logic [BYTE_W-1:0] w_lb, w_hb, w_ab;
        if (l < LANE_BYTES) begin : g_first
            assign w_lb = i_in_data.low_bits_first[OFS +: BYTE_W];
            assign w_hb = i_in_data.high_bits_first[OFS +: BYTE_W];
            assign w_ab = i_in_data.act_first[OFS +: BYTE_W];
        end else begin : g_second
            assign w_lb = i_in_data.low_bits_second[OFS +: BYTE_W];
            assign w_hb = i_in_data.high_bits_second[OFS +: BYTE_W];
            assign w_ab = i_in_data.act_second[OFS +: BYTE_W];
        end
        q6kq8k_lane u_lane (
            .i_low_byte  (w_lb),
            .i_high_byte (w_hb),
            .i_act_byte  (w_ab),
            .i_position  (i_in_data.group_position),
            .o_product   (w_prod[l])
        );
    end

    q6kq8k_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (w_adv),
        .i_prod      (r_s1_prod),
        .i_group_sum (r_s1_gs),
        .o_diff      (w_diff)
    );

    // The whole pipeline holds while the scaling unit works on a super-block.
    assign w_adv      = !w_busy;
    assign o_in_ready = w_adv;
    assign w_contrib  = r_s2_sc * w_diff;
    assign n_block_sum = r_block_sum
                       + {{(BLOCK_W-CONTRIB_W){r_s3_contrib[CONTRIB_W-1]}}, r_s3_contrib};
    assign w_start    = w_adv && r_s3_valid && (r_s3_end != END_NONE);

    always_comb begin
        w_req.sum       = n_block_sum;
        w_req.half      = r_s3_half;
        w_req.act_scale = r_s3_xd;
        w_req.row_end   = r_s3_end[END_ROW_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_block_sum <= '0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (r_s3_valid) begin
                r_block_sum <= (r_s3_end != END_NONE) ? '0 : n_block_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_prod    <= w_prod;
            r_s1_sc      <= i_in_data.sub_scale;
            r_s1_gs      <= i_in_data.group_act_sum;
            r_s1_half    <= i_in_data.weight_block_scale;
            r_s1_xd      <= i_in_data.act_block_scale;
            r_s1_end     <= i_in_data.end_mark;
            r_s2_sc      <= r_s1_sc;
            r_s2_half    <= r_s1_half;
            r_s2_xd      <= r_s1_xd;
            r_s2_end     <= r_s1_end;
            r_s3_contrib <= w_contrib;
            r_s3_half    <= r_s2_half;
            r_s3_xd      <= r_s2_xd;
            r_s3_end     <= r_s2_end;
        end
    end

    q6kq8k_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_req       (w_req),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `Q6K_ASSERT_NEXT(a_start_stalls, i_clk, i_rst_n, w_start, !o_in_ready, "no stall after start")
    `Q6K_ASSERT_NEXT(a_block_clear, i_clk, i_rst_n, w_start, r_block_sum == '0, "block sum kept")
    `Q6K_ASSERT_NEXT(a_block_accum, i_clk, i_rst_n, w_adv && r_s3_valid && (r_s3_end == END_NONE), r_block_sum == $past(n_block_sum), "accumulate")

endmodule

>>> design/q6kq8k_lane.sv
`timescale 1ns / 1ps

module q6kq8k_lane
    import q6kq8k_pkg::*;
(
    input  logic [BYTE_W-1:0]        i_low_byte,
    input  logic [BYTE_W-1:0]        i_high_byte,
    input  logic [BYTE_W-1:0]        i_act_byte,
    input  logic [1:0]               i_position,
    output logic signed [PROD_W-1:0] o_product
);

    logic [3:0]              w_nibble;
    logic [1:0]              w_pair;
    logic [CODE_W-1:0]       w_code;
    logic signed [PROD_W:0]  w_full;

    // Positions two and three take the upper nibble; the high pair sits at bits 2p+1:2p.
    assign w_nibble = i_position[1] ? i_low_byte[7:4] : i_low_byte[3:0];
    assign w_pair   = i_high_byte[{i_position, 1'b0} +: 2];
    assign w_code   = {w_pair, w_nibble};
    assign w_full   = $signed({1'b0, w_code}) * $signed(i_act_byte);
    assign o_product = w_full[PROD_W-1:0];

endmodule

>>> design/q6kq8k_merge.sv
`timescale 1ns / 1ps

module q6kq8k_merge
    import q6kq8k_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [PROD_W-1:0] i_prod [LANES],
    input  logic signed [GSUM_W-1:0] i_group_sum,
    output logic signed [DIFF_W-1:0] o_diff
);

    logic signed [TREE_W-1:0] w_l1 [LANES/2];
    logic signed [TREE_W-1:0] w_l2 [LANES/4];
    logic signed [TREE_W-1:0] w_l3 [LANES/8];
    logic signed [TREE_W-1:0] w_sum;
    logic signed [DIFF_W-1:0] n_diff;
    logic signed [DIFF_W-1:0] r_diff;

    always_comb begin
        for (int i = 0; i < LANES/2; i++) begin
            w_l1[i] = TREE_W'(i_prod[2*i]) + TREE_W'(i_prod[2*i+1]);
        end
        for (int i = 0; i < LANES/4; i++) begin
            w_l2[i] = w_l1[2*i] + w_l1[2*i+1];
        end
        for (int i = 0; i < LANES/8; i++) begin
            w_l3[i] = w_l2[2*i] + w_l2[2*i+1];
        end
        w_sum  = w_l3[0] + w_l3[1];
        // The codes carry an offset of 32, removed through the group activation sum.
        n_diff = DIFF_W'(w_sum) - (DIFF_W'(i_group_sum) <<< GSUM_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;

endmodule

>>> design/q6kq8k_scale.sv
`timescale 1ns / 1ps
`include "q6k_q8k_integer_dot_product_top_assert.svh"

module q6kq8k_scale
    import q6kq8k_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_blk_req  i_req,
    output logic      o_busy,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [SHIFTED_W-1:0] MAG_LIMIT = SHIFTED_W'(1) << (ACC_W - 1);
    localparam logic [ACC_W-1:0]     ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]     ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

    t_scale_state r_state, n_state;

    logic [BLOCK_W-1:0]     r_sum;
    logic [HALF_W-1:0]      r_half;
    logic [BLOCK_W-1:0]     r_xd;
    logic                   r_row;
    logic [BLOCK_W-1:0]     r_smag, r_xmag;
    logic [MANT_W-1:0]      r_mant;
    logic [RSHIFT_W-1:0]    r_rshift;
    logic [LSHIFT_W-1:0]    r_lshift;
    logic                   r_neg, r_nan;
    logic [SM_W-1:0]        r_sm;
    logic [PLO_W-1:0]       r_plo;
    logic [PHI_W-1:0]       r_phi;
    logic [PROD_FULL_W-1:0] r_p;
    logic [SHIFTED_W-1:0]   r_q;
    logic [ACC_W-1:0]       r_add;
    logic                   r_sat_prod;
    logic [ACC_W-1:0]       r_acc;
    logic                   r_row_sat;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    logic [4:0]             w_exp;
    logic [MANT_W-1:0]      n_mant;
    logic [RSHIFT_W-1:0]    n_rshift;
    logic [LSHIFT_W-1:0]    n_lshift;
    logic                   n_nan;
    logic [PROD_FULL_W-1:0] w_round;
    logic [ACC_W:0]         w_acc_sum;
    logic                   w_acc_ovf;
    logic                   w_slot_free;

    // fp16 decode: the value is mant * 2^(lshift - rshift - 24 + 24) in integer form.
    always_comb begin
        w_exp    = r_half[14:10];
        n_mant   = {1'b1, r_half[9:0]};
        n_rshift = '0;
        n_lshift = '0;
        n_nan    = 1'b0;
        if (w_exp == FP16_EXP_MAX) begin
            // Infinity is taken as the largest finite value.
            n_nan    = (r_half[9:0] != '0);
            n_mant   = FP16_INF_MANT;
            n_lshift = LSHIFT_W'(LSHIFT_MAX);
        end else if (w_exp == '0) begin
            n_mant   = {1'b0, r_half[9:0]};
            n_rshift = SUBNORM_SHIFT;
        end else if (w_exp >= FP16_UNBIAS) begin
            n_lshift = LSHIFT_W'(w_exp - FP16_UNBIAS);
        end else begin
            n_rshift = RSHIFT_W'(FP16_UNBIAS - w_exp);
        end
    end

    assign w_round = (r_rshift != '0)
                   ? (PROD_FULL_W'(1) << (r_rshift - RSHIFT_W'(1))) : '0;
    assign w_acc_sum = {r_acc[ACC_W-1], r_acc} + {r_add[ACC_W-1], r_add};
    assign w_acc_ovf = (w_acc_sum[ACC_W] != w_acc_sum[ACC_W-1]);
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_PREP;
            S_PREP:   n_state = S_MUL_A;
            S_MUL_A:  n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_ADD;
            S_ADD:    n_state = S_ROUND;
            S_ROUND:  n_state = S_SHIFT;
            S_SHIFT:  n_state = S_SAT;
            S_SAT:    n_state = S_ACC;
            S_ACC:    n_state = r_row ? S_EMIT : S_IDLE;
            S_EMIT:   if (w_slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_row_sat   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_acc     <= w_acc_ovf ? (w_acc_sum[ACC_W] ? ACC_MIN : ACC_MAX)
                                       : w_acc_sum[ACC_W-1:0];
                r_row_sat <= r_row_sat | r_sat_prod | w_acc_ovf;
            end
            if ((r_state == S_EMIT) && w_slot_free) begin
                r_out_valid <= 1'b1;
                r_acc       <= '0;
                r_row_sat   <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_sum  <= i_req.sum;
                    r_half <= i_req.half;
                    r_xd   <= i_req.act_scale;
                    r_row  <= i_req.row_end;
                end
            end
            S_PREP: begin
                r_smag   <= r_sum[BLOCK_W-1] ? (~r_sum + BLOCK_W'(1)) : r_sum;
                r_xmag   <= r_xd[BLOCK_W-1] ? (~r_xd + BLOCK_W'(1)) : r_xd;
                r_neg    <= r_half[HALF_W-1] ^ r_sum[BLOCK_W-1] ^ r_xd[BLOCK_W-1];
                r_mant   <= n_mant;
                r_rshift <= n_rshift;
                r_lshift <= n_lshift;
                r_nan    <= n_nan;
            end
            S_MUL_A:  r_sm  <= SM_W'(r_smag) * SM_W'(r_mant);
            S_MUL_LO: r_plo <= PLO_W'(r_sm[SPLIT_W-1:0]) * PLO_W'(r_xmag);
            S_MUL_HI: r_phi <= PHI_W'(r_sm[SM_W-1:SPLIT_W]) * PHI_W'(r_xmag);
            S_ADD:    r_p   <= (PROD_FULL_W'(r_phi) << SPLIT_W) + PROD_FULL_W'(r_plo);
            // Rounding on the magnitude gives ties away from zero.
            S_ROUND:  r_p   <= r_p + w_round;
            S_SHIFT: begin
                if (r_rshift != '0) begin
                    r_q <= SHIFTED_W'(r_p >> r_rshift);
                end else begin
                    r_q <= SHIFTED_W'(r_p) << r_lshift;
                end
            end
            S_SAT: begin
                if (r_nan) begin
                    r_add      <= '0;
                    r_sat_prod <= 1'b0;
                end else if (r_neg) begin
                    r_sat_prod <= (r_q > MAG_LIMIT);
                    r_add      <= (r_q > MAG_LIMIT) ? ACC_MIN : (~r_q[ACC_W-1:0] + ACC_W'(1));
                end else begin
                    r_sat_prod <= (r_q >= MAG_LIMIT);
                    r_add      <= (r_q >= MAG_LIMIT) ? ACC_MAX : r_q[ACC_W-1:0];
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    r_out_data.row_sum   <= r_acc;
                    r_out_data.saturated <= r_row_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `Q6K_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE, "start while busy")
    `Q6K_ASSERT_NEXT(a_nan_zero, i_clk, i_rst_n, (r_state == S_SAT) && r_nan, (r_add == '0) && !r_sat_prod, "nan adds")
    `Q6K_ASSERT_NEXT(a_emit_clear, i_clk, i_rst_n, (r_state == S_EMIT) && w_slot_free, o_out_valid && (r_acc == '0) && !r_row_sat, "emit")
    `Q6K_ASSERT_NOW(a_shift_dir, i_clk, i_rst_n, r_state == S_SHIFT, (r_rshift == '0) || (r_lshift == '0), "two shifts")

endmodule

>>> tb/q6k_q8k_integer_dot_product_top_tb.sv
`timescale 1ns / 1ps

module q6k_q8k_integer_dot_product_top_tb;
    import q6kq8k_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEM_TARGET  = 400;
    localparam int ROW_TARGET   = 30;

    localparam logic [1:0] END_BLOCK   = 2'd1;
    localparam logic [1:0] END_ROW     = 2'd2;
    localparam logic [1:0] END_ROW_ALT = 2'd3;

    localparam logic [15:0]        HALF_ONE     = 16'h3C00;
    localparam logic signed [31:0] ACT_SCALE_ONE = 32'h0100_0000;

    class row_scoreboard;
        localparam longint ROW_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
        localparam longint ROW_MIN = 64'h8000_0000_0000_0000;

        logic [31:0] block_sum;
        longint      row_acc;
        bit          row_sat;
        t_out_item   expected_rows[$];
        int          mismatch_count;
        int          rows_predicted;

        function new();
            block_sum      = '0;
            row_acc        = 0;
            row_sat        = 1'b0;
            mismatch_count = 0;
            rows_predicted = 0;
        endfunction

        // Scaled group term, sub_scale * (dot - 32 * group sum), kept to 32 bits.
        function logic [31:0] group_term(t_in_item g);
            logic [7:0]        lb;
            logic [7:0]        hb;
            logic signed [7:0] a;
            logic [5:0]        code;
            int                c;
            int                av;
            longint            dot;
            longint            term;
            dot = 0;
            for (int i = 0; i < 16; i++) begin
                lb = (i < 8) ? g.low_bits_first[i*8 +: 8] : g.low_bits_second[(i-8)*8 +: 8];
                hb = (i < 8) ? g.high_bits_first[i*8 +: 8] : g.high_bits_second[(i-8)*8 +: 8];
                a  = (i < 8) ? g.act_first[i*8 +: 8] : g.act_second[(i-8)*8 +: 8];
                code = {hb[2*g.group_position +: 2],
                        (g.group_position >= 2) ? lb[7:4] : lb[3:0]};
                c   = code;
                av  = a;
                dot = dot + c * av;
            end
            term = longint'(g.sub_scale) * (dot - 32 * longint'(g.group_act_sum));
            return term[31:0];
        endfunction

        // Product of the block sum with both scales, rounded to an integer and saturated to 64 bits.
        function longint scale_block_sum(logic [31:0] sum, logic [15:0] half,
                                         logic [31:0] xd, output bit sat);
            logic [10:0]  mant;
            int           k;
            bit           neg;
            logic [32:0]  smag;
            logic [32:0]  xmag;
            logic [127:0] p;
            sat = 1'b0;
            neg = half[15];
            if (half[14:10] == 5'h1F) begin
                // NaN contributes nothing; infinity acts as the largest finite value.
                if (half[9:0] != 10'd0)
                    return 0;
                mant = 11'h7FF;
                k    = 5;
            end else if (half[14:10] == 5'h00) begin
                mant = {1'b0, half[9:0]};
                k    = -24;
            end else begin
                mant = {1'b1, half[9:0]};
                k    = int'(half[14:10]) - 25;
            end
            if (sum[31]) begin
                smag = 33'h1_0000_0000 - sum;
                neg  = !neg;
            end else begin
                smag = sum;
            end
            if (xd[31]) begin
                xmag = 33'h1_0000_0000 - xd;
                neg  = !neg;
            end else begin
                xmag = xd;
            end
            p = smag * mant * xmag;
            // Right shifts round to nearest with ties away from zero on the magnitude.
            if (k < 0)
                p = (p + (128'd1 << (-k - 1))) >> (-k);
            else
                p = p << k;
            if (neg) begin
                if (p > 128'h8000_0000_0000_0000) begin
                    sat = 1'b1;
                    return ROW_MIN;
                end
                return longint'(64'd0 - p[63:0]);
            end
            if (p > 128'h7FFF_FFFF_FFFF_FFFF) begin
                sat = 1'b1;
                return ROW_MAX;
            end
            return longint'(p[63:0]);
        endfunction

        function void note_group(t_in_item g);
            bit                 prod_sat;
            longint             add;
            logic signed [64:0] total;
            block_sum = block_sum + group_term(g);
            if (g.end_mark == END_NONE)
                return;
            add = scale_block_sum(block_sum, g.weight_block_scale, g.act_block_scale,
                                  prod_sat);
            if (prod_sat)
                row_sat = 1'b1;
            total = row_acc;
            total = total + add;
            if (total > ROW_MAX) begin
                row_acc = ROW_MAX;
                row_sat = 1'b1;
            end else if (total < ROW_MIN) begin
                row_acc = ROW_MIN;
                row_sat = 1'b1;
            end else begin
                row_acc = total[63:0];
            end
            block_sum = '0;
            if (!g.end_mark[END_ROW_BIT])
                return;
            expected_rows.push_back('{row_sum: row_acc, saturated: row_sat});
            rows_predicted++;
            row_acc = 0;
            row_sat = 1'b0;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        task report(string msg);
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("ERROR: %s", msg);
        endtask

        task check_row(t_out_item got);
            t_out_item want;
            if (expected_rows.size() == 0) begin
                report($sformatf("row sum %0d arrived with no row pending", got.row_sum));
                return;
            end
            want = expected_rows.pop_front();
            if (got.row_sum !== want.row_sum)
                report($sformatf("row_sum %0d, expected %0d", got.row_sum, want.row_sum));
            if (got.saturated !== want.saturated)
                report($sformatf("saturated %0b, expected %0b", got.saturated,
                                 want.saturated));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    row_scoreboard rows;
    bit            calm;
    int            cycle_count;
    int            items_sent;

    q6k_q8k_integer_dot_product_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, a few long ones, none at all while calm is set.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] random_act_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h80;
        if (r == 1)
            return 8'h7F;
        return 8'($urandom);
    endfunction

    function automatic logic [11:0] act_total(logic [63:0] a0, logic [63:0] a1);
        int s;
        s = 0;
        for (int i = 0; i < 8; i++)
            s = s + int'($signed(a0[i*8 +: 8])) + int'($signed(a1[i*8 +: 8]));
        return 12'(s);
    endfunction

    function automatic logic [15:0] random_half();
        int   r;
        logic s;
        r = $urandom_range(0, 19);
        s = 1'($urandom);
        case (r)
            0: return {s, 5'h1F, 10'h000};
            1: return {s, 5'h1F, 10'($urandom_range(1, 1023))};
            2: return {s, 5'h00, 10'($urandom)};
            3: return 16'($urandom);
            default: return {s, 5'($urandom_range(5, 20)), 10'($urandom)};
        endcase
    endfunction

    function automatic logic signed [31:0] random_act_scale();
        int          r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        if (r == 1)
            return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        v = $urandom_range(0, 32'h0200_0000);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    function automatic t_in_item random_group(logic [1:0] mark);
        t_in_item g;
        g.low_bits_first   = {$urandom, $urandom};
        g.low_bits_second  = {$urandom, $urandom};
        g.high_bits_first  = {$urandom, $urandom};
        g.high_bits_second = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            g.act_first[i*8 +: 8]  = random_act_byte();
            g.act_second[i*8 +: 8] = random_act_byte();
        end
        g.group_position = 2'($urandom_range(0, 3));
        g.sub_scale      = 8'($urandom);
        // Usually the true activation sum, sometimes an arbitrary one.
        g.group_act_sum  = ($urandom_range(0, 9) < 7) ? act_total(g.act_first, g.act_second)
                                                      : 12'($urandom);
        g.weight_block_scale = random_half();
        g.act_block_scale    = random_act_scale();
        g.end_mark           = mark;
        return g;
    endfunction

    // All codes at 63 with every activation equal to one byte value.
    function automatic t_in_item full_group(logic signed [7:0] sub, logic [7:0] act_byte,
                                            logic signed [11:0] gsum);
        t_in_item g;
        g.low_bits_first     = '1;
        g.low_bits_second    = '1;
        g.high_bits_first    = '1;
        g.high_bits_second   = '1;
        g.group_position     = 2'd3;
        g.act_first          = {8{act_byte}};
        g.act_second         = {8{act_byte}};
        g.sub_scale          = sub;
        g.group_act_sum      = gsum;
        g.weight_block_scale = HALF_ONE;
        g.act_block_scale    = ACT_SCALE_ONE;
        g.end_mark           = END_NONE;
        return g;
    endfunction

    task automatic send_group(t_in_item g);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= g;
        do @(posedge clk); while (!in_ready);
        rows.note_group(g);
        items_sent++;
    endtask

    // Hold off the sender until every pending row has been transferred.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (rows.pending() != 0);
    endtask

    task automatic send_random_row();
        int         blocks;
        int         groups;
        logic [1:0] mark;
        blocks = $urandom_range(1, 3);
        for (int b = 0; b < blocks; b++) begin
            groups = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                 : $urandom_range(1, 6);
            for (int n = 0; n < groups; n++) begin
                if (n != groups - 1)
                    mark = END_NONE;
                else if (b != blocks - 1)
                    mark = END_BLOCK;
                else
                    mark = ($urandom_range(0, 7) == 0) ? END_ROW_ALT : END_ROW;
                send_group(random_group(mark));
            end
        end
    endtask

    task automatic send_noise_row();
        int count;
        count = $urandom_range(1, 8);
        for (int n = 0; n < count - 1; n++)
            send_group(random_group(2'($urandom_range(0, 3))));
        send_group(random_group(END_ROW));
    endtask

    // Enough large group terms to wrap the 32-bit super-block sum.
    task automatic send_wrapping_block();
        t_in_item g;
        for (int n = 0; n < 180; n++) begin
            g = full_group(-8'sd128, 8'h80, 12'sd2032);
            g.group_position = 2'($urandom_range(0, 3));
            if (n == 179)
                g.end_mark = END_ROW;
            send_group(g);
        end
    endtask

    initial begin : stimulus
        t_in_item g;
        int       row_index;
        rows       = new();
        items_sent = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        g = '0;
        g.end_mark = END_ROW;
        send_group(g);
        g = full_group(8'sd127, 8'h7F, -12'sd2048);
        g.end_mark = END_ROW;
        send_group(g);

        // Each position selects its nibble and its high-bit pair.
        for (int p = 0; p < 4; p++) begin
            g = random_group(END_NONE);
            g.low_bits_first     = 64'hA55A_3CC3_F00F_1234;
            g.low_bits_second    = 64'h0FF0_C33C_5AA5_9876;
            g.high_bits_first    = 64'hE4E4_E4E4_E4E4_E4E4;
            g.high_bits_second   = 64'h1B1B_1B1B_1B1B_1B1B;
            g.group_position     = 2'(p);
            g.sub_scale          = 8'sd5;
            g.group_act_sum      = act_total(g.act_first, g.act_second);
            g.weight_block_scale = HALF_ONE;
            g.act_block_scale    = ACT_SCALE_ONE;
            if (p == 3)
                g.end_mark = END_BLOCK;
            send_group(g);
        end
        g = random_group(END_ROW);
        g.weight_block_scale = 16'hBC00;
        g.act_block_scale    = ACT_SCALE_ONE;
        send_group(g);

        g = full_group(-8'sd128, 8'h80, 12'sd2032);
        g.weight_block_scale = 16'h0001;
        g.act_block_scale    = 32'sd3;
        g.end_mark           = END_ROW;
        send_group(g);

        // A product of exactly one half rounds away from zero in both signs.
        g = '0;
        g.low_bits_first     = 64'h1;
        g.act_first          = 64'h1;
        g.sub_scale          = 8'sd1;
        g.weight_block_scale = 16'h0001;
        g.act_block_scale    = 32'h0080_0000;
        g.end_mark           = END_ROW;
        send_group(g);
        g.weight_block_scale = 16'h8001;
        send_group(g);

        // A NaN weight scale drops its super-block from the row.
        g = random_group(END_BLOCK);
        g.weight_block_scale = 16'h7E00;
        send_group(g);
        g = random_group(END_ROW);
        g.weight_block_scale = HALF_ONE;
        g.act_block_scale    = ACT_SCALE_ONE;
        send_group(g);

        g = full_group(8'sd127, 8'h7F, -12'sd2048);
        g.weight_block_scale = 16'h7C00;
        g.act_block_scale    = 32'h7FFF_FFFF;
        g.end_mark           = END_ROW;
        send_group(g);
        g.weight_block_scale = 16'hFC00;
        send_group(g);

        g = random_group(END_ROW_ALT);
        g.weight_block_scale = HALF_ONE;
        g.act_block_scale    = ACT_SCALE_ONE;
        send_group(g);

        // Two in-range super-block products that overflow the row sum together.
        g = full_group(8'sd127, 8'h7F, -12'sd2048);
        g.weight_block_scale = 16'h7BFF;
        g.act_block_scale    = 32'h0040_0000;
        g.end_mark           = END_BLOCK;
        send_group(g);
        g.end_mark = END_ROW;
        send_group(g);
        g.weight_block_scale = 16'hFBFF;
        g.end_mark           = END_BLOCK;
        send_group(g);
        g.end_mark = END_ROW;
        send_group(g);

        g = random_group(END_ROW);
        g.group_act_sum = act_total(g.act_first, g.act_second) ^ 12'h555;
        send_group(g);

        send_wrapping_block();
        row_index = 0;
        while (items_sent < ITEM_TARGET || rows.rows_predicted < ROW_TARGET) begin
            if ($urandom_range(0, 6) == 0)
                send_noise_row();
            else
                send_random_row();
            if (row_index % 12 == 11)
                wait_drained();
            row_index++;
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (rows.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rows.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : receiver
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                rows.check_row(out_data);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    // Alternate between stretches with random gaps and stretches without any.
    initial begin : calm_toggle
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(100, 400)) @(negedge clk);
            calm = !calm;
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
